FILE: rtl/grid_flood_fill_top_assert.svh
// assertion macros shared by the flood fill rtl
`ifndef GRID_FLOOD_FILL_TOP_ASSERT_SVH
`define GRID_FLOOD_FILL_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, checked on every rising edge out of reset
`define GFF_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("grid flood fill assertion failed");
// next-cycle implication
`define GFF_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("grid flood fill assertion failed");
`else
`define GFF_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define GFF_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

FILE: rtl/gff_pkg.sv
// shared constants and types for the grid flood fill block
`default_nettype none
package gff_pkg;

  // default geometry and color depth
  localparam int GRID_COLS_DEF  = 128;
  localparam int GRID_ROWS_DEF  = 32;
  localparam int COLOR_BITS_DEF = 8;

  // fixed port field widths
  localparam int REQ_W   = 2;
  localparam int POS_X_W = 7;
  localparam int POS_Y_W = 5;
  localparam int COLOR_W = 8;

  typedef logic [REQ_W-1:0] req_t;

  // request codes
  localparam req_t REQ_WRITE = 2'd0;
  localparam req_t REQ_FILL  = 2'd1;
  localparam req_t REQ_READ  = 2'd2;

  // neighbor selection codes for the address unit
  typedef logic [2:0] dir_t;
  localparam dir_t DIR_SELF  = 3'd0;
  localparam dir_t DIR_LEFT  = 3'd1;
  localparam dir_t DIR_RIGHT = 3'd2;
  localparam dir_t DIR_DOWN  = 3'd3;
  localparam dir_t DIR_UP    = 3'd4;

endpackage
`default_nettype wire

FILE: rtl/grid_flood_fill_top.sv
// grid flood fill top: request sequencer, cell store and position stack
// cell write: result in the next cycle, a new item may follow at once
// cell read: ram read data registered, then result registered from ST_READ; busy for one cycle, off-grid like a write
// fill: seed checked in ST_SEED, then per recolored cell one stack pop (ST_POP, ST_LOAD) and,
//   per neighbor inside the grid, one grid ram access (ST_NB read, then ST_CHK compare and write)
// results are one-cycle strobes; rst_n (sync) clears control, rams unreset
`default_nettype none
`include "grid_flood_fill_top_assert.svh"
module grid_flood_fill_top #(
  parameter int GRID_COLS  = gff_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS  = gff_pkg::GRID_ROWS_DEF,
  parameter int COLOR_BITS = gff_pkg::COLOR_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [gff_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic [gff_pkg::POS_X_W-1:0]  in_pos_x,
  input  wire logic [gff_pkg::POS_Y_W-1:0]  in_pos_y,
  input  wire logic [gff_pkg::COLOR_W-1:0]  in_color,
  input  wire logic [gff_pkg::COLOR_W-1:0]  in_match_color,
  output logic                              out_valid,
  output logic      [gff_pkg::COLOR_W-1:0]  out_read_color,
  output logic                              out_filled
);

  import gff_pkg::*;

  localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
  localparam int XW = $clog2(GRID_COLS);
  localparam int YW = $clog2(GRID_ROWS);
  localparam int AW = $clog2(CELL_COUNT);
  localparam int TW = $clog2(CELL_COUNT + 1);
  localparam int SW = XW + YW;
  localparam int CB = COLOR_BITS;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_SEED = 3'd2;
  localparam logic [2:0] ST_POP  = 3'd3;
  localparam logic [2:0] ST_LOAD = 3'd4;
  localparam logic [2:0] ST_NB   = 3'd5;
  localparam logic [2:0] ST_CHK  = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [XW-1:0]      x_r, x_nxt;
  logic [YW-1:0]      y_r, y_nxt;
  dir_t               dir_r, dir_nxt;
  logic [CB-1:0]      new_c_r, new_c_nxt;
  logic [CB-1:0]      old_c_r, old_c_nxt;
  logic [TW-1:0]      top_r, top_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0] out_read_color_r, out_read_color_nxt;
  logic               out_filled_r, out_filled_nxt;

  logic               accept;
  logic               in_grid;
  logic [CB-1:0]      in_c;
  logic [CB-1:0]      in_m;
  logic [XW-1:0]      unit_x;
  logic [YW-1:0]      unit_y;
  dir_t               unit_dir;
  logic               nb_ok;
  logic [XW-1:0]      nb_x;
  logic [YW-1:0]      nb_y;
  logic [AW-1:0]      nb_addr;
  logic               grid_we;
  logic [CB-1:0]      grid_wdata;
  logic [CB-1:0]      grid_rdata;
  logic               stk_we;
  logic [SW-1:0]      stk_rdata;
  logic [TW-1:0]      top_dec;
  logic               cell_match;

  assign accept = start && !busy;
  assign in_grid = (int'(in_pos_x) < GRID_COLS) && (int'(in_pos_y) < GRID_ROWS);
  assign in_c   = CB'(in_color);
  assign in_m   = CB'(in_match_color);
  assign top_dec = top_r - TW'(1);
  assign cell_match = (grid_rdata == old_c_r);

  // address unit input: request position when idle, else the current cell (seed) or its neighbor in dir_r
  always_comb begin
    if (state_r == ST_IDLE) begin
      unit_x   = XW'(in_pos_x);
      unit_y   = YW'(in_pos_y);
      unit_dir = DIR_SELF;
    end else if (state_r == ST_SEED) begin
      unit_x   = x_r;
      unit_y   = y_r;
      unit_dir = DIR_SELF;
    end else begin
      unit_x   = x_r;
      unit_y   = y_r;
      unit_dir = dir_r;
    end
  end

  gff_nbr #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_nbr (
    .base_x  (unit_x),
    .base_y  (unit_y),
    .dir     (unit_dir),
    .nb_ok   (nb_ok),
    .nb_x    (nb_x),
    .nb_y    (nb_y),
    .nb_addr (nb_addr)
  );

  // grid cell store, read and write always at the unit address
  gff_ram #(
    .WIDTH (CB),
    .DEPTH (CELL_COUNT)
  ) u_grid (
    .clk   (clk),
    .we    (grid_we),
    .waddr (nb_addr),
    .wdata (grid_wdata),
    .raddr (nb_addr),
    .rdata (grid_rdata)
  );

  // pending position stack, push at top, pop from top minus one
  gff_ram #(
    .WIDTH (SW),
    .DEPTH (CELL_COUNT)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (top_r[AW-1:0]),
    .wdata ({nb_y, nb_x}),
    .raddr (top_dec[AW-1:0]),
    .rdata (stk_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt          = state_r;
    x_nxt              = x_r;
    y_nxt              = y_r;
    dir_nxt            = dir_r;
    new_c_nxt          = new_c_r;
    old_c_nxt          = old_c_r;
    top_nxt            = top_r;
    out_valid_nxt      = 1'b0;
    out_read_color_nxt = '0;
    out_filled_nxt     = 1'b0;
    grid_we            = 1'b0;
    grid_wdata         = new_c_r;
    stk_we             = 1'b0;
    case (state_r)
      ST_IDLE: begin
        grid_wdata = in_c;
        if (accept) begin
          case (in_req_type)
            REQ_WRITE: begin
              grid_we       = in_grid;
              out_valid_nxt = 1'b1;
            end
            REQ_READ: begin
              if (in_grid) begin
                state_nxt = ST_READ;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            REQ_FILL: begin
              x_nxt     = XW'(in_pos_x);
              y_nxt     = YW'(in_pos_y);
              new_c_nxt = in_c;
              old_c_nxt = in_m;
              if (in_grid && (in_c != in_m)) begin
                state_nxt = ST_SEED;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        out_valid_nxt      = 1'b1;
        out_read_color_nxt = COLOR_W'(grid_rdata);
        state_nxt          = ST_IDLE;
      end
      ST_SEED: begin
        if (cell_match) begin
          grid_we   = 1'b1;
          stk_we    = 1'b1;
          top_nxt   = top_r + TW'(1);
          state_nxt = ST_POP;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_POP: begin
        if (top_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_filled_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          top_nxt   = top_dec;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        y_nxt     = stk_rdata[SW-1:XW];
        x_nxt     = stk_rdata[XW-1:0];
        dir_nxt   = DIR_LEFT;
        state_nxt = ST_NB;
      end
      ST_NB: begin
        if (nb_ok) begin
          state_nxt = ST_CHK;
        end else if (dir_r == DIR_UP) begin
          state_nxt = ST_POP;
        end else begin
          dir_nxt = dir_r + dir_t'(1);
        end
      end
      ST_CHK: begin
        // recolor and push on a match, then move to the next neighbor or, after up, back to pop
        if (cell_match) begin
          grid_we = 1'b1;
          stk_we  = 1'b1;
          top_nxt = top_r + TW'(1);
        end
        if (dir_r == DIR_UP) begin
          state_nxt = ST_POP;
        end else begin
          dir_nxt   = dir_r + dir_t'(1);
          state_nxt = ST_NB;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    x_r              <= x_nxt;
    y_r              <= y_nxt;
    dir_r            <= dir_nxt;
    new_c_r          <= new_c_nxt;
    old_c_r          <= old_c_nxt;
    out_read_color_r <= out_read_color_nxt;
    out_filled_r     <= out_filled_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_read_color = out_read_color_r;
  assign out_filled     = out_filled_r && out_valid_r;

  // checks on the sequencer and stack
  `GFF_ASSERT_IMP(a_top_bound, clk, rst_n, 1'b1, top_r <= TW'(CELL_COUNT))
  `GFF_ASSERT_IMP(a_idle_empty, clk, rst_n, state_r == ST_IDLE, top_r == '0)
  `GFF_ASSERT_NXT(a_write_result, clk, rst_n, accept && (in_req_type == REQ_WRITE), out_valid)
  `GFF_ASSERT_NXT(a_fill_done, clk, rst_n, (state_r == ST_POP) && (top_r == '0), out_valid && out_filled)
  `GFF_ASSERT_IMP(a_filled_src, clk, rst_n, out_filled, $past(state_r) == ST_POP)

endmodule
`default_nettype wire

FILE: rtl/gff_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module gff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/gff_nbr.sv
// shared cell address unit: neighbor step, edge check and linear address
`default_nettype none
module gff_nbr #(
  parameter int GRID_COLS = gff_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = gff_pkg::GRID_ROWS_DEF,
  localparam int XW = $clog2(GRID_COLS),
  localparam int YW = $clog2(GRID_ROWS),
  localparam int AW = $clog2(GRID_COLS * GRID_ROWS)
) (
  input  wire logic [XW-1:0]      base_x,
  input  wire logic [YW-1:0]      base_y,
  input  wire gff_pkg::dir_t      dir,
  output logic                    nb_ok,
  output logic      [XW-1:0]      nb_x,
  output logic      [YW-1:0]      nb_y,
  output logic      [AW-1:0]      nb_addr
);

  import gff_pkg::*;

  // step one cell in the selected direction, skipping the grid edge
  always_comb begin
    nb_ok = 1'b0;
    nb_x  = base_x;
    nb_y  = base_y;
    case (dir)
      DIR_SELF: begin
        nb_ok = 1'b1;
      end
      DIR_LEFT: begin
        nb_ok = (base_x != '0);
        nb_x  = base_x - XW'(1);
      end
      DIR_RIGHT: begin
        nb_ok = (base_x != XW'(GRID_COLS - 1));
        nb_x  = base_x + XW'(1);
      end
      DIR_DOWN: begin
        nb_ok = (base_y != YW'(GRID_ROWS - 1));
        nb_y  = base_y + YW'(1);
      end
      DIR_UP: begin
        nb_ok = (base_y != '0);
        nb_y  = base_y - YW'(1);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  // row-major linear address, multiply by a constant
  assign nb_addr = AW'(nb_y) * AW'(GRID_COLS) + AW'(nb_x);

endmodule
`default_nettype wire
